[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error("check failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/ffa_pkg.sv]
// ---------------------------------------------------------------------------
// ffa_pkg
// shared constants and types of the first-fit allocator
// ---------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
  localparam int UNITS_DEF    = 64;
  localparam int RESERVED_DEF = 8;
  localparam int TAG_W        = 16;
  localparam int LEN_W        = 7;
  localparam int START_W      = 6;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;

  typedef enum logic [1:0] {
    KIND_EVICT  = 2'd0,
    KIND_PLACE  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic             busy;
    logic [TAG_W-1:0] owner;
    logic [TAG_W-1:0] order;
  } entry_t;
endpackage
`default_nettype wire

[rtl/core/first_fit_allocator_fifo_evict.sv]
// ---------------------------------------------------------------------------
// first_fit_allocator_fifo_evict
// first-fit contiguous allocator over a unit map with oldest-first eviction
// ---------------------------------------------------------------------------
// After reset the block clears all UNITS entries of its unit map and takes
// no word meanwhile. Each request then walks the unit memory: one full
// scan to find the lowest fitting run, and while nothing fits, an eviction
// pass over the non-reserved units and a fresh scan, each eviction reported
// as its own word; the request is rejected when nothing is left to evict.
// A placement writes one unit per cycle. A zero or oversized request is
// rejected without a scan.
`default_nettype none
`include "assert_macros.svh"
module first_fit_allocator_fifo_evict #(
  parameter int UNITS          = ffa_pkg::UNITS_DEF,
  parameter int RESERVED_UNITS = ffa_pkg::RESERVED_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ffa_pkg::IN_TDATA_W-1:0] in_tdata,   // process_tag, request_units
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ffa_pkg::OUT_TDATA_W-1:0]     out_tdata,  // tag_out, start_unit, already_present
  output logic [1:0]                          out_tuser,  // result_kind
  output logic                                out_tlast
);
  import ffa_pkg::*;

  localparam int IW  = $clog2(UNITS);
  localparam int CW  = $clog2(UNITS + 1);
  localparam int CAP = UNITS - RESERVED_UNITS;
  localparam int LW  = (CW > LEN_W) ? CW : LEN_W;

  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_EVICT  = 7'b0010000,
    S_PLACE  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  entry_t mem [UNITS];
  entry_t rd_data;
  logic   rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t wr_data;

  state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [IW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    run_r, run_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    start_r, start_nxt;
  logic             dup_r, dup_nxt;
  logic             first_r, first_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic [TAG_W-1:0] old_r, old_nxt;
  logic [TAG_W-1:0] new_r, new_nxt;
  logic [TAG_W-1:0] ev_r, ev_nxt;
  logic             ov_r, ov_nxt;
  kind_t            okind_r, okind_nxt;
  logic [TAG_W-1:0] otag_r, otag_nxt;
  logic [IW-1:0]    ostart_r, ostart_nxt;
  logic             odup_r, odup_nxt;
  logic             olast_r, olast_nxt;

  logic [TAG_W-1:0] in_tag;
  logic [LEN_W-1:0] in_len;
  logic [CW-1:0]    run_inc;

  assign in_tag  = in_tdata[TAG_W-1:0];
  assign in_len  = in_tdata[TAG_W+LEN_W-1:TAG_W];
  assign run_inc = run_r + CW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;  pv_nxt = 1'b0;  pidx_nxt = pidx_r;
    run_nxt = run_r;  found_nxt = found_r;  start_nxt = start_r;
    dup_nxt = dup_r;  first_nxt = first_r;  tag_nxt = tag_r;  len_nxt = len_r;
    rem_nxt = rem_r;  k_nxt = k_r;  old_nxt = old_r;  new_nxt = new_r;
    ev_nxt = ev_r;  ov_nxt = ov_r;  okind_nxt = okind_r;  otag_nxt = otag_r;
    ostart_nxt = ostart_r;  odup_nxt = odup_r;  olast_nxt = olast_r;
    rd_en = 1'b0;  rd_addr = cnt_r[IW-1:0];
    wr_en = 1'b0;  wr_addr = cnt_r[IW-1:0];  wr_data = '0;
    case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        wr_data.busy = (cnt_r < CW'(RESERVED_UNITS));
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(UNITS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          tag_nxt = in_tag;  len_nxt = in_len;
          if (in_len == '0 || LW'(in_len) > LW'(CAP)) begin
            ov_nxt = 1'b1;  okind_nxt = KIND_REJECT;  otag_nxt = in_tag;
            ostart_nxt = '0;  odup_nxt = 1'b0;  olast_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            k_nxt = '0;  dup_nxt = 1'b0;  first_nxt = 1'b1;
            cnt_nxt = '0;  run_nxt = '0;  found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < CW'(UNITS)) begin
          rd_en = 1'b1;  pv_nxt = 1'b1;  pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
        if (pv_r) begin
          if (rd_data.busy) begin
            run_nxt = '0;
            if (first_r && pidx_r >= IW'(RESERVED_UNITS) && rd_data.owner == tag_r)
              dup_nxt = 1'b1;
          end else begin
            run_nxt = run_inc;
            if (!found_r && run_inc >= CW'(len_r)) begin
              found_nxt = 1'b1;
              start_nxt = pidx_r - run_r[IW-1:0];
            end
          end
          if (pidx_r == IW'(UNITS - 1)) state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        first_nxt = 1'b0;
        if (found_r) begin
          cnt_nxt = CW'(start_r);  rem_nxt = len_r;  state_nxt = S_PLACE;
        end else if (old_r == new_r || k_r >= CW'(CAP)) begin
          ov_nxt = 1'b1;  okind_nxt = KIND_REJECT;  otag_nxt = tag_r;
          ostart_nxt = '0;  odup_nxt = 1'b0;  olast_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = CW'(RESERVED_UNITS);  ev_nxt = '0;  state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (cnt_r < CW'(UNITS)) begin
          rd_en = 1'b1;  pv_nxt = 1'b1;  pidx_nxt = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
        if (pv_r) begin
          wr_addr = pidx_r;
          if (rd_data.busy && rd_data.order == old_r) begin
            ev_nxt = rd_data.owner;
            wr_en = 1'b1;
          end
          if (pidx_r == IW'(UNITS - 1)) begin
            ov_nxt = 1'b1;  okind_nxt = KIND_EVICT;
            otag_nxt = (rd_data.busy && rd_data.order == old_r) ? rd_data.owner : ev_r;
            ostart_nxt = '0;  odup_nxt = 1'b0;  olast_nxt = 1'b0;
            old_nxt = old_r + TAG_W'(1);  k_nxt = k_r + CW'(1);
            state_nxt = S_EMIT;
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
        wr_data.busy = 1'b1;  wr_data.owner = tag_r;  wr_data.order = new_r;
        cnt_nxt = cnt_r + CW'(1);
        rem_nxt = rem_r - LEN_W'(1);
        if (rem_r == LEN_W'(1)) begin
          ov_nxt = 1'b1;  okind_nxt = KIND_PLACE;  otag_nxt = tag_r;
          ostart_nxt = start_r;  odup_nxt = dup_r;  olast_nxt = 1'b1;
          new_nxt = new_r + TAG_W'(1);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = '0;  run_nxt = '0;  found_nxt = 1'b0;  state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;  cnt_r <= '0;  pv_r <= 1'b0;  ov_r <= 1'b0;
      old_r <= TAG_W'(1);  new_r <= TAG_W'(1);  first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  cnt_r <= cnt_nxt;  pv_r <= pv_nxt;  ov_r <= ov_nxt;
      old_r <= old_nxt;  new_r <= new_nxt;  first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;  run_r <= run_nxt;  found_r <= found_nxt;
    start_r <= start_nxt;  dup_r <= dup_nxt;  tag_r <= tag_nxt;  len_r <= len_nxt;
    rem_r <= rem_nxt;  k_r <= k_nxt;  ev_r <= ev_nxt;  okind_r <= okind_nxt;
    otag_r <= otag_nxt;  ostart_r <= ostart_nxt;  odup_r <= odup_nxt;
    olast_r <= olast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, odup_r, START_W'(ostart_r), otag_r};

  `ASSERT_CLK(a_valid_in_emit, clk, rst_n, out_tvalid |-> state_r == S_EMIT)
  `ASSERT_CLK(a_no_overlap, clk, rst_n, in_tready |-> !out_tvalid)
  `ASSERT_CLK(a_place_last, clk, rst_n, (out_tvalid && out_tuser != KIND_EVICT) |-> out_tlast)
  `ASSERT_NEXT(a_evict_rescan, clk, rst_n, out_tvalid && out_tready && !out_tlast, state_r == S_SCAN)
endmodule
`default_nettype wire

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// stream-level test of the first-fit allocator with oldest-first eviction
// ---------------------------------------------------------------------------
// Requests are driven on the input stream with random gaps, save for a final
// run without them. A local model of the unit map works out the evictions,
// placement or rejection of each accepted request, and a monitor compares
// every result word against the oldest expected word, field by field.
`default_nettype none
module tb_top;
  import ffa_pkg::*;

  localparam int NUNITS = UNITS_DEF;
  localparam int NRES   = RESERVED_DEF;
  localparam int CAP    = NUNITS - NRES;
  localparam int LIMIT  = 10000000;

  typedef struct packed {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [START_W-1:0] start;
    logic              dup;
    logic              last;
  } alloc_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  // unit map model
  logic              map_busy [NUNITS];
  logic [TAG_W-1:0]  map_owner[NUNITS];
  logic [TAG_W-1:0]  map_order[NUNITS];
  logic [TAG_W-1:0]  oldest_seq, newest_seq;

  alloc_word_t pending_words[$];
  int  errors = 0;
  int  n_sent = 0;
  int  n_words = 0;
  int  n_evict = 0;
  int  cycles = 0;
  bit  allow_idle = 1'b1;
  int  gap_left = 0;

  first_fit_allocator_fifo_evict DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void map_clear();
    for (int i = 0; i < NUNITS; i++) begin
      map_busy[i] = (i < NRES);
      map_owner[i] = '0;
      map_order[i] = '0;
    end
    oldest_seq = 16'd1;
    newest_seq = 16'd1;
  endfunction

  function automatic bit first_run(int len, output int at);
    int run;
    run = 0;
    at = 0;
    for (int i = 0; i < NUNITS; i++) begin
      if (map_busy[i]) run = 0;
      else begin
        run++;
        if (run >= len) begin
          at = i + 1 - run;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [TAG_W-1:0] evict_oldest();
    logic [TAG_W-1:0] t;
    t = '0;
    for (int i = NRES; i < NUNITS; i++) begin
      if (map_busy[i] && map_order[i] == oldest_seq) begin
        t = map_owner[i];
        map_busy[i] = 1'b0;
        map_owner[i] = '0;
        map_order[i] = '0;
      end
    end
    oldest_seq = oldest_seq + 16'd1;
    return t;
  endfunction

  function automatic void predict_request(logic [TAG_W-1:0] tag, int len);
    int at, k;
    bit dup;
    at = 0;
    k = 0;
    dup = 1'b0;
    if (len == 0 || len > CAP) begin
      pending_words.push_back('{KIND_REJECT, tag, '0, 1'b0, 1'b1});
      return;
    end
    for (int i = NRES; i < NUNITS; i++)
      if (map_busy[i] && map_owner[i] == tag) dup = 1'b1;
    while (!first_run(len, at)) begin
      if (oldest_seq == newest_seq || k >= CAP) begin
        pending_words.push_back('{KIND_REJECT, tag, '0, 1'b0, 1'b1});
        return;
      end
      pending_words.push_back('{KIND_EVICT, evict_oldest(), '0, 1'b0, 1'b0});
      k++;
    end
    for (int i = at; i < at + len && i < NUNITS; i++) begin
      map_busy[i] = 1'b1;
      map_owner[i] = tag;
      map_order[i] = newest_seq;
    end
    newest_seq = newest_seq + 16'd1;
    pending_words.push_back('{KIND_PLACE, tag, START_W'(at), dup, 1'b1});
  endfunction

  // result side: random stalls and checking
  always @(posedge clk) begin
    alloc_word_t exp_w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_words <= n_words + 1;
        if (pending_words.size() == 0) begin
          $error("unexpected word kind=%0d tag=%h", out_tuser, out_tdata[15:0]);
          errors++;
        end else begin
          exp_w = pending_words.pop_front();
          if (exp_w.kind == KIND_EVICT) n_evict <= n_evict + 1;
          if (out_tuser !== exp_w.kind) begin
            $error("result_kind expected %0d actual %0d", exp_w.kind, out_tuser);
            errors++;
          end
          if (out_tdata[15:0] !== exp_w.tag) begin
            $error("tag_out expected %h actual %h", exp_w.tag, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[21:16] !== exp_w.start) begin
            $error("start_unit expected %0d actual %0d", exp_w.start, out_tdata[21:16]);
            errors++;
          end
          if (out_tdata[22] !== exp_w.dup) begin
            $error("already_present expected %0d actual %0d", exp_w.dup, out_tdata[22]);
            errors++;
          end
          if (out_tlast !== exp_w.last) begin
            $error("last_result expected %0d actual %0d", exp_w.last, out_tlast);
            errors++;
          end
        end
      end
      if (!allow_idle) out_tready <= 1'b1;
      else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tdata <= {1'b0, len, tag};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(tag, int'(len));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_request(16'h0000, 7'd0);
    send_request(16'hFFFF, 7'd127);
    send_request(16'h1234, 7'd57);
    send_request(16'hFFFF, 7'd1);
    send_request(16'h0000, 7'd56);
    send_request(16'hA5A5, 7'd64);
  endtask

  task automatic test_duplicates_and_evictions();
    send_request(16'h0001, 7'd10);
    send_request(16'h0001, 7'd10);
    send_request(16'h0002, 7'd20);
    send_request(16'h0003, 7'd16);
    send_request(16'h0001, 7'd30);
    send_request(16'h5555, 7'd56);
    send_request(16'hAAAA, 7'd3);
    send_request(16'h0000, 7'd5);
    send_request(16'h0000, 7'd2);
  endtask

  task automatic test_drain_pause();
    send_request(16'h0042, 7'd8);
    wait_drained();
    send_request(16'h0042, 7'd8);
  endtask

  task automatic test_random(int count);
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: len = LEN_W'($urandom_range(0, 127));
        1: len = LEN_W'($urandom_range(30, 56));
        default: len = LEN_W'($urandom_range(1, 14));
      endcase
      if ($urandom_range(0, 3) == 0) tag = TAG_W'($urandom_range(0, 7));
      else tag = TAG_W'($urandom);
      send_request(tag, len);
    end
  endtask

  initial begin
    map_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_duplicates_and_evictions();
    test_drain_pause();
    test_random(220);
    allow_idle = 1'b0;
    test_random(40);
    wait_drained();
    $display("sent %0d requests, checked %0d result words, %0d evictions",
             n_sent, n_words, n_evict);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[first_fit_allocator_fifo_evict.f]
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/first_fit_allocator_fifo_evict.sv
test/tb_top.sv
